>>> rtl/core/sbeu_pkg.sv
// Shared types and constants of the stack bytecode execute unit.
// No dependencies; the core and the divider refer to it by scope, the bench imports it.
`default_nettype none
package sbeu_pkg;

    typedef enum logic [1:0] {
        ACT_START = 2'd0,
        ACT_ARG   = 2'd1,
        ACT_BEGIN = 2'd2,
        ACT_EXEC  = 2'd3
    } t_action;

    typedef enum logic [4:0] {
        OP_EXIT    = 5'd0,
        OP_ADD     = 5'd1,
        OP_SUB     = 5'd2,
        OP_MUL     = 5'd3,
        OP_DIV     = 5'd4,
        OP_PUSH    = 5'd5,
        OP_POP     = 5'd6,
        OP_PRINT   = 5'd7,
        OP_LT      = 5'd8,
        OP_EQ      = 5'd9,
        OP_LOAD    = 5'd10,
        OP_STORE   = 5'd11,
        OP_JZ      = 5'd12,
        OP_JMP     = 5'd13,
        OP_LOADBP  = 5'd14,
        OP_STOREBP = 5'd15,
        OP_CALL    = 5'd16,
        OP_RET     = 5'd17
    } t_opcode;

    localparam logic [4:0] OP_LAST = 5'd17;

    typedef enum logic [2:0] {
        ERR_NONE   = 3'd0,
        ERR_DIVZ   = 3'd1,
        ERR_UNDER  = 3'd2,
        ERR_OVER   = 3'd3,
        ERR_INDEX  = 3'd4,
        ERR_RET    = 3'd5,
        ERR_OPCODE = 3'd6
    } t_err;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD1,
        S_RD2,
        S_RD3,
        S_DIV,
        S_EXEC,
        S_OUT
    } t_state;

    localparam logic [2:0] REG_RESULT_SLOT = 3'd0;

    typedef struct packed {
        logic               start;
        logic signed [15:0] dividend;
        logic signed [15:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic [15:0]        next_pc;
        logic               print_valid;
        logic signed [15:0] print_value;
        logic               done_res;
        logic signed [15:0] result_value;
        t_err               error_code;
    } t_result;

endpackage
`default_nettype wire

>>> rtl/core/sbeu_if.sv
// Request and result channel interfaces of the stack bytecode execute unit.
// Valid/ready handshake with payload; no dependencies.
`default_nettype none
interface sbeu_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         action;
    logic [4:0]         opcode;
    logic signed [15:0] operand;

    modport source(output valid, action, opcode, operand, input ready);
    modport sink(input valid, action, opcode, operand, output ready);
endinterface

interface sbeu_out_if;
    logic               valid;
    logic               ready;
    logic [15:0]        next_pc;
    logic               print_valid;
    logic signed [15:0] print_value;
    logic               done_res;
    logic signed [15:0] result_value;
    logic [2:0]         error_code;

    modport source(output valid, next_pc, print_valid, print_value, done_res,
                   result_value, error_code, input ready);
    modport sink(input valid, next_pc, print_valid, print_value, done_res,
                 result_value, error_code, output ready);
endinterface
`default_nettype wire

>>> rtl/core/stack_bytecode_execute_unit_core.sv
// Top level of the stack bytecode execute unit: sequencer, state, RAMs.
// Depends on sbeu_pkg, sbeu_if, sbeu_ram and sbeu_div.
//
//   channel   dir  handshake            payload
//   i_req     in   valid/ready          action, opcode, operand
//   o_res     out  valid/ready          next_pc, print, done, result, error
//   apb       in   psel/penable/pready  paddr, pwdata, prdata (result slot)
//
// Sequence: control actions and execute-while-stopped go through EXEC and OUT;
// instructions go through RD1, RD2, RD3 (three stack RAM read slots), EXEC and
// OUT, with the output handshake in OUT. Divide waits in DIV for the bit-serial divider.
// One request at a time: i_req.ready is high only while idle.
// Reset is synchronous; the stack RAMs are not cleared, the depths are.
`default_nettype none
module stack_bytecode_execute_unit_core #(
    parameter int STACK_DEPTH  = 256,
    parameter int RETURN_DEPTH = 64,
    parameter int PC_BITS      = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    sbeu_in_if.sink          i_req,
    sbeu_out_if.source       o_res,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output      logic [31:0] prdata,
    output      logic        pready
);
    localparam int SA = $clog2(STACK_DEPTH);
    localparam int SD = $clog2(STACK_DEPTH + 1);
    localparam int RA = $clog2(RETURN_DEPTH);
    localparam int RD = $clog2(RETURN_DEPTH + 1);

    sbeu_pkg::t_state   r_state, n_state;
    logic [1:0]         r_action;
    logic [4:0]         r_opcode;
    logic signed [15:0] r_operand;
    logic [SD-1:0]      r_depth;
    logic [15:0]        r_base;
    logic [RD-1:0]      r_rdepth;
    logic [PC_BITS-1:0] r_pc;
    logic               r_running;
    logic               r_slot_en;
    logic [15:0]        r_bottom;
    logic [15:0]        r_b;
    logic [15:0]        r_a;
    logic [PC_BITS:0]   r_ret;
    logic [15:0]        r_quo;
    sbeu_pkg::t_result  r_res;

    // ---------------- configuration port ----------------
    logic w_cfg_we;
    assign pready   = 1'b1;
    assign w_cfg_we = psel && penable && pwrite && (paddr[2] == sbeu_pkg::REG_RESULT_SLOT[0]);
    assign prdata   = (paddr[2] == sbeu_pkg::REG_RESULT_SLOT[0]) ? {31'd0, r_slot_en} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_en <= 1'b1;
        end else if (w_cfg_we) begin
            r_slot_en <= pwdata[0];
        end
    end

    // ---------------- stack addressing ----------------
    logic [SD-1:0] w_top, w_sec, w_inc;
    logic [RD-1:0] w_rtop, w_rinc;
    logic          w_bp;
    logic [17:0]   w_idx;
    logic          w_idx_ok;
    logic          w_full, w_rfull;

    assign w_top    = r_depth - SD'(1);
    assign w_sec    = r_depth - SD'(2);
    assign w_inc    = r_depth + SD'(1);
    assign w_rtop   = r_rdepth - RD'(1);
    assign w_rinc   = r_rdepth + RD'(1);
    assign w_full   = (r_depth == SD'(STACK_DEPTH));
    assign w_rfull  = (r_rdepth == RD'(RETURN_DEPTH));
    assign w_bp     = (r_opcode == sbeu_pkg::OP_LOADBP) || (r_opcode == sbeu_pkg::OP_STOREBP);
    assign w_idx    = {{2{r_operand[15]}}, r_operand} + (w_bp ? {2'b00, r_base} : 18'd0);
    assign w_idx_ok = !w_idx[17] && (w_idx[16:0] < 17'(r_depth));

    // ---------------- memories ----------------
    logic          w_we;
    logic [SA-1:0] w_waddr;
    logic [15:0]   w_wdata;
    logic [SA-1:0] w_raddr;
    logic [15:0]   w_rdata;
    logic          w_rwe;
    logic [PC_BITS:0] w_rwdata;
    logic [PC_BITS:0] w_rrdata;

    sbeu_ram #(.WIDTH(16), .DEPTH(STACK_DEPTH)) u_opstack (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    sbeu_ram #(.WIDTH(PC_BITS + 1), .DEPTH(RETURN_DEPTH)) u_retstack (
        .i_clk   (i_clk),
        .i_we    (w_rwe),
        .i_waddr (r_rdepth[RA-1:0]),
        .i_wdata (w_rwdata),
        .i_raddr (w_rtop[RA-1:0]),
        .o_rdata (w_rrdata)
    );

    // ---------------- divider ----------------
    sbeu_pkg::t_div_req w_div_req;
    logic               w_div_done;
    logic signed [15:0] w_div_q;
    logic               w_div_path;

    assign w_div_path = (r_opcode == sbeu_pkg::OP_DIV) && (r_depth >= SD'(2))
                        && (r_b != 16'd0);

    sbeu_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_div_req),
        .o_done     (w_div_done),
        .o_quotient (w_div_q)
    );

    // ---------------- sequencer: next state ----------------
    logic w_acc_in, w_acc_out;
    assign w_acc_in  = i_req.valid && i_req.ready;
    assign w_acc_out = o_res.valid && o_res.ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sbeu_pkg::S_IDLE: begin
                if (w_acc_in) begin
                    n_state = (i_req.action == sbeu_pkg::ACT_EXEC && r_running)
                              ? sbeu_pkg::S_RD1 : sbeu_pkg::S_EXEC;
                end
            end
            sbeu_pkg::S_RD1: n_state = sbeu_pkg::S_RD2;
            sbeu_pkg::S_RD2: n_state = sbeu_pkg::S_RD3;
            sbeu_pkg::S_RD3: n_state = w_div_path ? sbeu_pkg::S_DIV : sbeu_pkg::S_EXEC;
            sbeu_pkg::S_DIV: begin
                if (w_div_done) begin
                    n_state = sbeu_pkg::S_EXEC;
                end
            end
            sbeu_pkg::S_EXEC: n_state = sbeu_pkg::S_OUT;
            sbeu_pkg::S_OUT: begin
                if (w_acc_out) begin
                    n_state = sbeu_pkg::S_IDLE;
                end
            end
            default: n_state = sbeu_pkg::S_IDLE;
        endcase
    end

    // ---------------- sequencer: outputs ----------------
    always_comb begin
        i_req.ready        = (r_state == sbeu_pkg::S_IDLE);
        o_res.valid        = (r_state == sbeu_pkg::S_OUT);
        w_raddr            = w_top[SA-1:0];
        w_div_req.start    = 1'b0;
        w_div_req.dividend = w_rdata;
        w_div_req.divisor  = r_b;
        unique case (r_state)
            sbeu_pkg::S_RD2: begin
                // second operand: below top, or the indexed entry for loads
                w_raddr = (r_opcode == sbeu_pkg::OP_LOAD || r_opcode == sbeu_pkg::OP_LOADBP)
                          ? w_idx[SA-1:0] : w_sec[SA-1:0];
            end
            sbeu_pkg::S_RD3: w_div_req.start = w_div_path;
            default: w_raddr = w_top[SA-1:0];
        endcase
    end

    // ---------------- execute step ----------------
    logic [PC_BITS-1:0] w_pc_inc, w_pc_rel;
    logic [31:0]        w_imm32;
    logic [31:0]        w_mul;
    logic [31:0]        w_pc32;

    assign w_imm32  = {{16{r_operand[15]}}, r_operand};
    assign w_pc_inc = r_pc + PC_BITS'(1);
    assign w_pc_rel = r_pc + w_imm32[PC_BITS-1:0];
    assign w_mul    = r_a * r_b;

    sbeu_pkg::t_err     v_err;
    logic               v_we;
    logic [SA-1:0]      v_waddr;
    logic [15:0]        v_wdata;
    logic [SD-1:0]      v_depth;
    logic [15:0]        v_base;
    logic               v_rwe;
    logic [PC_BITS:0]   v_rwdata;
    logic [RD-1:0]      v_rdepth;
    logic [PC_BITS-1:0] v_pc;
    logic               v_run;
    logic               v_pv;
    logic [15:0]        v_pval;
    logic               v_done;
    logic [15:0]        v_bottom;
    logic [15:0]        v_alu;

    always_comb begin
        v_err    = sbeu_pkg::ERR_NONE;
        v_we     = 1'b0;
        v_waddr  = r_depth[SA-1:0];
        v_wdata  = 16'd0;
        v_depth  = r_depth;
        v_base   = r_base;
        v_rwe    = 1'b0;
        v_rwdata = '0;
        v_rdepth = r_rdepth;
        v_pc     = r_pc;
        v_run    = r_running;
        v_pv     = 1'b0;
        v_pval   = 16'd0;
        v_done   = 1'b0;
        v_alu    = 16'd0;
        unique case (r_action)
            sbeu_pkg::ACT_START: begin
                v_depth  = r_slot_en ? SD'(1) : SD'(0);
                v_rdepth = '0;
                v_base   = 16'd0;
                v_pc     = '0;
                v_run    = 1'b0;
                v_we     = r_slot_en;
                v_waddr  = '0;
            end
            sbeu_pkg::ACT_ARG: begin
                if (w_full) begin
                    v_err = sbeu_pkg::ERR_OVER;
                end else begin
                    v_we    = 1'b1;
                    v_wdata = r_operand;
                    v_depth = w_inc;
                end
            end
            sbeu_pkg::ACT_BEGIN: begin
                if (w_full) begin
                    v_err = sbeu_pkg::ERR_OVER;
                end else if (w_rfull) begin
                    v_err = sbeu_pkg::ERR_RET;
                end else begin
                    v_we     = 1'b1;
                    v_depth  = w_inc;
                    v_rwe    = 1'b1;      // null return address, valid bit clear
                    v_rdepth = w_rinc;
                    v_base   = 16'(w_inc);
                    v_pc     = '0;
                    v_run    = 1'b1;
                end
            end
            default: begin
                if (!r_running) begin
                    v_err = sbeu_pkg::ERR_NONE;
                end else if (r_opcode > sbeu_pkg::OP_LAST) begin
                    v_err = sbeu_pkg::ERR_OPCODE;
                end else begin
                    unique case (r_opcode)
                        sbeu_pkg::OP_EXIT: begin
                            v_run  = 1'b0;
                            v_done = 1'b1;
                        end
                        sbeu_pkg::OP_ADD, sbeu_pkg::OP_SUB, sbeu_pkg::OP_MUL,
                        sbeu_pkg::OP_DIV, sbeu_pkg::OP_LT, sbeu_pkg::OP_EQ: begin
                            unique case (r_opcode)
                                sbeu_pkg::OP_ADD: v_alu = r_a + r_b;
                                sbeu_pkg::OP_SUB: v_alu = r_a - r_b;
                                sbeu_pkg::OP_MUL: v_alu = w_mul[15:0];
                                sbeu_pkg::OP_DIV: v_alu = r_quo;
                                sbeu_pkg::OP_LT:  v_alu = {15'd0, $signed(r_a) < $signed(r_b)};
                                default:          v_alu = {15'd0, r_a == r_b};
                            endcase
                            if (r_depth < SD'(2)) begin
                                v_err = sbeu_pkg::ERR_UNDER;
                            end else if (r_opcode == sbeu_pkg::OP_DIV && r_b == 16'd0) begin
                                v_err = sbeu_pkg::ERR_DIVZ;
                            end else begin
                                v_we    = 1'b1;
                                v_waddr = w_sec[SA-1:0];
                                v_wdata = v_alu;
                                v_depth = w_top;
                                v_pc    = w_pc_inc;
                            end
                        end
                        sbeu_pkg::OP_PUSH: begin
                            if (w_full) begin
                                v_err = sbeu_pkg::ERR_OVER;
                            end else begin
                                v_we    = 1'b1;
                                v_wdata = r_operand;
                                v_depth = w_inc;
                                v_pc    = w_pc_inc;
                            end
                        end
                        sbeu_pkg::OP_POP, sbeu_pkg::OP_PRINT: begin
                            if (r_depth == '0) begin
                                v_err = sbeu_pkg::ERR_UNDER;
                            end else begin
                                v_depth = w_top;
                                v_pc    = w_pc_inc;
                                v_pv    = (r_opcode == sbeu_pkg::OP_PRINT);
                                v_pval  = v_pv ? r_b : 16'd0;
                            end
                        end
                        sbeu_pkg::OP_LOAD, sbeu_pkg::OP_LOADBP: begin
                            if (w_full) begin
                                v_err = sbeu_pkg::ERR_OVER;
                            end else if (!w_idx_ok) begin
                                v_err = sbeu_pkg::ERR_INDEX;
                            end else begin
                                v_we    = 1'b1;
                                v_wdata = r_a;
                                v_depth = w_inc;
                                v_pc    = w_pc_inc;
                            end
                        end
                        sbeu_pkg::OP_STORE, sbeu_pkg::OP_STOREBP: begin
                            if (r_depth == '0) begin
                                v_err = sbeu_pkg::ERR_UNDER;
                            end else if (!w_idx_ok) begin
                                v_err = sbeu_pkg::ERR_INDEX;
                            end else begin
                                v_we    = 1'b1;
                                v_waddr = w_idx[SA-1:0];
                                v_wdata = r_b;
                                v_depth = w_top;
                                v_pc    = w_pc_inc;
                            end
                        end
                        sbeu_pkg::OP_JZ: begin
                            if (r_depth == '0) begin
                                v_err = sbeu_pkg::ERR_UNDER;
                            end else begin
                                v_depth = w_top;
                                v_pc    = (r_b == 16'd0) ? w_pc_rel : w_pc_inc;
                            end
                        end
                        sbeu_pkg::OP_JMP: v_pc = w_pc_rel;
                        sbeu_pkg::OP_CALL: begin
                            if (w_full) begin
                                v_err = sbeu_pkg::ERR_OVER;
                            end else if (w_rfull) begin
                                v_err = sbeu_pkg::ERR_RET;
                            end else begin
                                v_we     = 1'b1;
                                v_wdata  = r_base;
                                v_depth  = w_inc;
                                v_rwe    = 1'b1;
                                v_rwdata = {1'b1, w_pc_inc};
                                v_rdepth = w_rinc;
                                v_base   = 16'(w_inc);
                                v_pc     = w_pc_rel;
                            end
                        end
                        default: begin
                            // return: frame base comes back from the stack top
                            if (r_rdepth == '0) begin
                                v_err = sbeu_pkg::ERR_RET;
                            end else if (r_depth == '0) begin
                                v_err = sbeu_pkg::ERR_UNDER;
                            end else begin
                                v_rdepth = w_rtop;
                                v_depth  = w_top;
                                v_base   = r_b;
                                if (!r_ret[PC_BITS]) begin
                                    v_run  = 1'b0;
                                    v_done = 1'b1;
                                end else begin
                                    v_pc = r_ret[PC_BITS-1:0];
                                end
                            end
                        end
                    endcase
                end
            end
        endcase
        // any fault leaves the state alone and stops the run
        if (v_err != sbeu_pkg::ERR_NONE) begin
            v_we     = 1'b0;
            v_rwe    = 1'b0;
            v_depth  = r_depth;
            v_base   = r_base;
            v_rdepth = r_rdepth;
            v_pc     = r_pc;
            v_run    = 1'b0;
            v_pv     = 1'b0;
            v_pval   = 16'd0;
            v_done   = 1'b0;
        end
        v_bottom = (v_we && v_waddr == '0) ? v_wdata : r_bottom;
    end

    assign w_we     = (r_state == sbeu_pkg::S_EXEC) && v_we;
    assign w_waddr  = v_waddr;
    assign w_wdata  = v_wdata;
    assign w_rwe    = (r_state == sbeu_pkg::S_EXEC) && v_rwe;
    assign w_rwdata = v_rwdata;
    assign w_pc32   = 32'(v_pc);

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= sbeu_pkg::S_IDLE;
            r_depth   <= '0;
            r_base    <= 16'd0;
            r_rdepth  <= '0;
            r_pc      <= '0;
            r_running <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == sbeu_pkg::S_EXEC) begin
                r_depth   <= v_depth;
                r_base    <= v_base;
                r_rdepth  <= v_rdepth;
                r_pc      <= v_pc;
                r_running <= v_run;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc_in) begin
            r_action  <= i_req.action;
            r_opcode  <= i_req.opcode;
            r_operand <= i_req.operand;
        end
        if (r_state == sbeu_pkg::S_RD2) begin
            r_b   <= w_rdata;
            r_ret <= w_rrdata;
        end
        if (r_state == sbeu_pkg::S_RD3) begin
            r_a <= w_rdata;
        end
        if (w_div_done) begin
            r_quo <= w_div_q;
        end
        if (r_state == sbeu_pkg::S_EXEC) begin
            r_bottom           <= v_bottom;
            r_res.next_pc      <= w_pc32[15:0];
            r_res.print_valid  <= v_pv;
            r_res.print_value  <= v_pval;
            r_res.done_res     <= v_done;
            r_res.result_value <= (v_done && v_depth != '0) ? v_bottom : 16'd0;
            r_res.error_code   <= v_err;
        end
    end

    assign o_res.next_pc      = r_res.next_pc;
    assign o_res.print_valid  = r_res.print_valid;
    assign o_res.print_value  = r_res.print_value;
    assign o_res.done_res     = r_res.done_res;
    assign o_res.result_value = r_res.result_value;
    assign o_res.error_code   = r_res.error_code;

    // ---------------- assertions ----------------
    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= SD'(STACK_DEPTH))
        else $error("operand stack depth beyond capacity");

    a_rdepth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rdepth <= RD'(RETURN_DEPTH))
        else $error("return stack depth beyond capacity");

    a_fault_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.error_code != sbeu_pkg::ERR_NONE)
        |-> (!o_res.done_res && !o_res.print_valid && !r_running))
        else $error("fault result carries side effects");

    a_div_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sbeu_pkg::S_DIV) |-> (r_opcode == sbeu_pkg::OP_DIV && r_b != 16'd0))
        else $error("divider wait without a valid divide");
endmodule
`default_nettype wire

>>> rtl/core/sbeu_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module sbeu_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

>>> rtl/core/sbeu_div.sv
// Iterative signed 16-bit divider, one quotient bit per cycle, truncating.
// Depends on sbeu_pkg for the request struct.
`default_nettype none
module sbeu_div (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire sbeu_pkg::t_div_req  i_req,
    output      logic                o_done,
    output      logic signed [15:0]  o_quotient
);
    logic [15:0] r_rem;
    logic [15:0] r_quo;
    logic [15:0] r_dvs;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_neg;
    logic        r_done;
    logic [16:0] w_shift;
    logic [17:0] w_trial;
    logic [15:0] w_mag_a;
    logic [15:0] w_mag_b;

    assign w_mag_a = i_req.dividend[15] ? 16'(-i_req.dividend) : i_req.dividend;
    assign w_mag_b = i_req.divisor[15] ? 16'(-i_req.divisor) : i_req.divisor;
    assign w_shift = {r_rem, r_quo[15]};
    assign w_trial = {1'b0, w_shift} - {2'b00, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 5'd0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd16;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= 16'd0;
            r_quo <= w_mag_a;
            r_dvs <= w_mag_b;
            r_neg <= i_req.dividend[15] ^ i_req.divisor[15];
        end else if (r_busy) begin
            if (!w_trial[17]) begin
                r_rem <= w_trial[15:0];
                r_quo <= {r_quo[14:0], 1'b1};
            end else begin
                r_rem <= w_shift[15:0];
                r_quo <= {r_quo[14:0], 1'b0};
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? 16'(-r_quo) : r_quo;
endmodule
`default_nettype wire

>>> verif/stack_bytecode_execute_unit_core_tb.sv
// Self-checking bench for the stack bytecode execute unit core.
// Depends on sbeu_pkg, sbeu_if and the core; drives requests, predicts results, checks them.
module stack_bytecode_execute_unit_core_tb;
    import sbeu_pkg::*;

    localparam int SDEPTH = 256;
    localparam int RDEPTH = 64;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [1:0]         action;
        logic [4:0]         opcode;
        logic signed [15:0] operand;
    } t_request;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    sbeu_in_if  req_if();
    sbeu_out_if res_if();

    stack_bytecode_execute_unit_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(req_if.sink), .o_res(res_if.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #1 i_clk = ~i_clk;

    // Predictor state: a private copy of the machine.
    logic [15:0] m_stack [SDEPTH];
    int          m_depth, m_base, m_rdepth;
    logic [16:0] m_rstack [RDEPTH];
    logic [15:0] m_pc;
    bit          m_running;
    bit          m_slot_en;

    t_request    pending_reqs[$];
    t_result     expected_results[$];
    int          mismatches = 0, n_checked = 0, n_prints = 0, n_done = 0;
    int          cycle_count = 0;
    bit          in_flight = 1'b0;
    bit          all_queued = 1'b0;

    function automatic t_result make_result(bit pv, logic [15:0] pval, bit done, t_err err);
        t_result r;
        r.next_pc      = m_pc;
        r.print_valid  = pv;
        r.print_value  = pv ? pval : 16'd0;
        r.done_res     = done;
        r.result_value = (done && m_depth > 0) ? m_stack[0] : 16'd0;
        r.error_code   = err;
        return r;
    endfunction

    function automatic t_result machine_fault(t_err err);
        m_running = 1'b0;
        return make_result(0, 0, 0, err);
    endfunction

    // Executes one request on the private machine and returns the expected result.
    function automatic t_result execute_request(t_request q);
        logic [15:0] a, b, r;
        int          idx;
        logic [16:0] ra;
        t_opcode     op;
        op = t_opcode'(q.opcode);
        case (q.action)
            ACT_START: begin
                m_depth = 0; m_rdepth = 0; m_base = 0; m_pc = 0; m_running = 0;
                if (m_slot_en) begin
                    m_stack[0] = 0;
                    m_depth = 1;
                end
                return make_result(0, 0, 0, ERR_NONE);
            end
            ACT_ARG: begin
                if (m_depth >= SDEPTH) return machine_fault(ERR_OVER);
                m_stack[m_depth++] = q.operand;
                return make_result(0, 0, 0, ERR_NONE);
            end
            ACT_BEGIN: begin
                if (m_depth >= SDEPTH) return machine_fault(ERR_OVER);
                if (m_rdepth >= RDEPTH) return machine_fault(ERR_RET);
                m_stack[m_depth++] = 0;
                m_rstack[m_rdepth++] = 17'd0;
                m_base = m_depth; m_pc = 0; m_running = 1;
                return make_result(0, 0, 0, ERR_NONE);
            end
            default: ;
        endcase
        if (!m_running) return make_result(0, 0, 0, ERR_NONE);
        if (q.opcode > OP_LAST) return machine_fault(ERR_OPCODE);
        case (op)
            OP_EXIT: begin
                m_running = 0;
                return make_result(0, 0, 1, ERR_NONE);
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_LT, OP_EQ: begin
                if (m_depth < 2) return machine_fault(ERR_UNDER);
                b = m_stack[m_depth-1];
                a = m_stack[m_depth-2];
                if (op == OP_DIV && b == 0) return machine_fault(ERR_DIVZ);
                case (op)
                    OP_ADD: r = a + b;
                    OP_SUB: r = a - b;
                    OP_MUL: r = a * b;
                    // -32768/-1 wraps
                    OP_DIV: r = 16'(int'($signed(a)) / int'($signed(b)));
                    OP_LT:  r = {15'd0, $signed(a) < $signed(b)};
                    default: r = {15'd0, a == b};
                endcase
                m_depth -= 2;
                m_stack[m_depth++] = r;
            end
            OP_PUSH: begin
                if (m_depth >= SDEPTH) return machine_fault(ERR_OVER);
                m_stack[m_depth++] = q.operand;
            end
            OP_POP, OP_PRINT: begin
                if (m_depth < 1) return machine_fault(ERR_UNDER);
                r = m_stack[--m_depth];
                m_pc = m_pc + 1;
                return make_result(op == OP_PRINT, r, 0, ERR_NONE);
            end
            OP_LOAD, OP_LOADBP: begin
                idx = int'(q.operand) + ((op == OP_LOADBP) ? m_base : 0);
                if (m_depth >= SDEPTH) return machine_fault(ERR_OVER);
                if (idx < 0 || idx >= m_depth) return machine_fault(ERR_INDEX);
                m_stack[m_depth] = m_stack[idx];
                m_depth++;
            end
            OP_STORE, OP_STOREBP: begin
                idx = int'(q.operand) + ((op == OP_STOREBP) ? m_base : 0);
                if (m_depth < 1) return machine_fault(ERR_UNDER);
                if (idx < 0 || idx >= m_depth) return machine_fault(ERR_INDEX);
                m_stack[idx] = m_stack[m_depth-1];
                m_depth--;
            end
            OP_JZ: begin
                if (m_depth < 1) return machine_fault(ERR_UNDER);
                r = m_stack[--m_depth];
                m_pc = (r == 0) ? m_pc + q.operand : m_pc + 1;
                return make_result(0, 0, 0, ERR_NONE);
            end
            OP_JMP: begin
                m_pc = m_pc + q.operand;
                return make_result(0, 0, 0, ERR_NONE);
            end
            OP_CALL: begin
                if (m_depth >= SDEPTH) return machine_fault(ERR_OVER);
                if (m_rdepth >= RDEPTH) return machine_fault(ERR_RET);
                m_stack[m_depth++] = 16'(m_base);
                m_rstack[m_rdepth++] = {1'b1, m_pc + 16'd1};
                m_base = m_depth;
                m_pc = m_pc + q.operand;
                return make_result(0, 0, 0, ERR_NONE);
            end
            default: begin  // return
                if (m_rdepth < 1) return machine_fault(ERR_RET);
                if (m_depth < 1) return machine_fault(ERR_UNDER);
                ra = m_rstack[--m_rdepth];
                m_base = m_stack[--m_depth];
                if (!ra[16]) begin
                    // null return address ends the run
                    m_running = 0;
                    return make_result(0, 0, 1, ERR_NONE);
                end
                m_pc = ra[15:0];
                return make_result(0, 0, 0, ERR_NONE);
            end
        endcase
        m_pc = m_pc + 1;
        return make_result(0, 0, 0, ERR_NONE);
    endfunction

    // Driver: bursts with random gaps; predicts at acceptance.
    int gap_left = 0, burst_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
            req_if.action <= '0; req_if.opcode <= '0; req_if.operand <= '0;
        end else begin
            automatic bit taken = req_if.valid && req_if.ready;
            automatic t_result predicted;
            if (taken) begin
                predicted = execute_request('{req_if.action, req_if.opcode, req_if.operand});
                expected_results = {expected_results, predicted};
                void'(pending_reqs.pop_front());
            end
            if (req_if.valid && !taken) begin
                // hold the current request
            end else if (gap_left > 0) begin
                gap_left--;
                req_if.valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                req_if.valid   <= 1'b1;
                req_if.action  <= pending_reqs[0].action;
                req_if.opcode  <= pending_reqs[0].opcode;
                req_if.operand <= pending_reqs[0].operand;
                if (burst_left > 0) burst_left--;
                else begin
                    burst_left = $urandom_range(0, 12);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // Receiver stalls follow a rotating pattern mixed with random runs.
    logic [15:0] stall_pattern = 16'b0010_0000_1100_0101;
    always @(posedge i_clk) begin
        if (!i_rst_n) res_if.ready <= 1'b0;
        else begin
            stall_pattern <= {stall_pattern[14:0], stall_pattern[15]};
            res_if.ready <= (cycle_count % 3000 < 1000) ? 1'b1
                          : !(stall_pattern[0] || $urandom_range(0, 7) == 0);
        end
    end

    // Monitor: compare each accepted result against the oldest expectation.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            automatic t_result got;
            automatic t_result want;
            got = '{res_if.next_pc, res_if.print_valid, res_if.print_value,
                    res_if.done_res, res_if.result_value, t_err'(res_if.error_code)};
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
            end else begin
                want = expected_results.pop_front();
                n_checked++;
                n_prints += got.print_valid;
                n_done += got.done_res;
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch #%0d: expected %p, got %p", n_checked, want, got);
                end
            end
        end
    end

    task automatic queue_req(t_action act, t_opcode op, int val);
        t_request q;
        q = '{act, op, 16'(val)};
        pending_reqs = {pending_reqs, q};
    endtask

    task automatic queue_raw(logic [4:0] op, int val);
        t_request q;
        q = '{ACT_EXEC, op, 16'(val)};
        pending_reqs = {pending_reqs, q};
    endtask

    task automatic drain();
        wait (pending_reqs.size() == 0 && expected_results.size() == 0);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_slot_reg(bit val);
        @(posedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= 3'(4 * REG_RESULT_SLOT);
        pwdata <= {31'd0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        m_slot_en = val;
    endtask

    // Random program: mostly well-formed runs with random contents.
    task automatic queue_random_run();
        int n;
        queue_req(ACT_START, OP_EXIT, 0);
        repeat ($urandom_range(0, 3)) queue_req(ACT_ARG, OP_EXIT, $urandom);
        queue_req(ACT_BEGIN, OP_EXIT, 0);
        n = $urandom_range(3, 20);
        repeat (n) begin
            case ($urandom_range(0, 11))
                0, 1: queue_req(ACT_EXEC, OP_PUSH,
                          ($urandom_range(0, 1)) ? $urandom_range(0, 5) : $urandom);
                2: queue_req(ACT_EXEC, t_opcode'($urandom_range(1, 4)), 0);
                3: queue_req(ACT_EXEC, ($urandom_range(0, 1)) ? OP_LT : OP_EQ, 0);
                4: queue_req(ACT_EXEC, t_opcode'($urandom_range(6, 7)), 0);
                5: queue_req(ACT_EXEC, t_opcode'($urandom_range(10, 11)),
                          $signed($urandom_range(0, 6)) - 1);
                6: queue_req(ACT_EXEC, t_opcode'($urandom_range(14, 15)),
                          $signed($urandom_range(0, 6)) - 3);
                7: queue_req(ACT_EXEC, t_opcode'($urandom_range(12, 13)), $urandom);
                8: queue_req(ACT_EXEC, OP_CALL, $urandom);
                9: queue_req(ACT_EXEC, OP_RET, 0);
                10: queue_raw(5'($urandom_range(0, 31)), $urandom);
                default: queue_req(t_action'($urandom_range(0, 3)),
                                   t_opcode'($urandom_range(0, 17)), $urandom);
            endcase
        end
        if ($urandom_range(0, 1)) queue_req(ACT_EXEC, OP_EXIT, 0);
    endtask

    initial begin
        m_depth = 0; m_base = 0; m_rdepth = 0; m_pc = 0; m_running = 0; m_slot_en = 1;
        for (int k = 0; k < SDEPTH; k++) m_stack[k] = 0;
        for (int k = 0; k < RDEPTH; k++) m_rstack[k] = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes, every opcode but EXIT and ADD in a run, the faults, reset value of the slot register.
        queue_req(ACT_EXEC, OP_ADD, 0);                 // execute while stopped
        queue_req(ACT_START, OP_EXIT, 0);
        queue_req(ACT_ARG, OP_EXIT, -32768);
        queue_req(ACT_BEGIN, OP_EXIT, 0);
        queue_req(ACT_EXEC, OP_PUSH, -1);
        queue_req(ACT_EXEC, OP_DIV, 0);                 // 0 / -1 gives 0
        queue_req(ACT_EXEC, OP_PUSH, 32767);
        queue_req(ACT_EXEC, OP_MUL, 0);
        queue_req(ACT_EXEC, OP_PUSH, 3);
        queue_req(ACT_EXEC, OP_SUB, 0);
        queue_req(ACT_EXEC, OP_PUSH, 0);
        queue_req(ACT_EXEC, OP_LT, 0);
        queue_req(ACT_EXEC, OP_LOAD, 0);
        queue_req(ACT_EXEC, OP_EQ, 0);
        queue_req(ACT_EXEC, OP_LOADBP, -1);
        queue_req(ACT_EXEC, OP_STOREBP, -1);            // store onto the entry below top
        queue_req(ACT_EXEC, OP_STORE, 0);
        queue_req(ACT_EXEC, OP_CALL, 4);
        queue_req(ACT_EXEC, OP_JMP, -32768);
        queue_req(ACT_EXEC, OP_RET, 0);
        queue_req(ACT_EXEC, OP_JZ, 5);
        queue_req(ACT_EXEC, OP_PRINT, 0);
        queue_req(ACT_EXEC, OP_POP, 0);                 // underflow
        queue_req(ACT_BEGIN, OP_EXIT, 0);
        queue_req(ACT_EXEC, OP_PUSH, 0);
        queue_req(ACT_EXEC, OP_DIV, 0);                 // divide by zero
        drain();
        write_slot_reg(1'b0);
        queue_req(ACT_START, OP_EXIT, 0);
        queue_req(ACT_BEGIN, OP_EXIT, 0);
        queue_req(ACT_EXEC, OP_STORE, 5);               // bad index
        queue_req(ACT_BEGIN, OP_EXIT, 0);
        queue_raw(5'd31, 0);                            // bad opcode
        queue_req(ACT_BEGIN, OP_EXIT, 0);
        queue_req(ACT_EXEC, OP_RET, 0);                 // null return ends the run
        drain();

        // Overflow of both stacks, with slot enabled.
        write_slot_reg(1'b1);
        queue_req(ACT_START, OP_EXIT, 0);
        queue_req(ACT_BEGIN, OP_EXIT, 0);
        repeat (RDEPTH - 1) queue_req(ACT_EXEC, OP_CALL, 1);
        queue_req(ACT_EXEC, OP_CALL, 1);                // return stack full
        repeat (SDEPTH - RDEPTH - 1) queue_req(ACT_ARG, OP_EXIT, $urandom);
        queue_req(ACT_ARG, OP_EXIT, 1);                 // operand stack full
        queue_req(ACT_BEGIN, OP_EXIT, 0);
        drain();

        // Random phases across register settings.
        for (int phase = 0; phase < 4; phase++) begin
            write_slot_reg(phase[0]);
            repeat (5) queue_random_run();
            drain();
        end
        all_queued = 1'b1;
    end

    initial begin
        wait (all_queued && pending_reqs.size() == 0 && expected_results.size() == 0);
        $display("covered %0d results: %0d prints, %0d finished runs, all opcodes and faults",
                 n_checked, n_prints, n_done);
        if (mismatches == 0) $display("[ OK ] regression clean");
        else $display("[FAIL] regression broken");
        $finish;
    end

    always @(posedge i_clk) begin
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("[FAIL] regression broken");
            $finish;
        end
    end
endmodule
